// File: src/ipmd_pkg.sv
// Shared types, codes and helpers for the intra 4x4 prediction mode derivation block.
// No dependencies; ipmd_front, ipmd_back and the top level use this package by scoped names.
package ipmd_pkg;

  // Field widths fixed by the bitstream syntax
  localparam int MB_ADDR_W = 13;
  localparam int CFG_W     = 10;
  localparam int MODE_W    = 4;
  localparam int WORD_W    = 64;

  // Mode and position constants
  localparam logic [3:0] MODE_DC    = 4'd2;
  localparam logic [3:0] BOTTOM_ROW = 4'(3 << 2);
  localparam logic [1:0] RIGHT_COL  = 2'd3;
  localparam logic [3:0] LAST_BLOCK = 4'd15;

  // Where a neighbour mode comes from
  localparam logic [1:0] SRC_CUR   = 2'd0;  // current macroblock register
  localparam logic [1:0] SRC_STORE = 2'd1;  // neighbour macroblock in the store
  localparam logic [1:0] SRC_DC    = 2'd2;  // neighbour present but not intra 4x4
  localparam logic [1:0] SRC_MISS  = 2'd3;  // neighbour unavailable

  typedef struct packed {
    logic [12:0] mb_address;
    logic [3:0]  block_index;
    logic        use_predicted;
    logic [2:0]  remaining_mode;
    logic        left_available;
    logic        top_available;
    logic        left_is_i4;
    logic        top_is_i4;
  } in_item_t;

  typedef struct packed {
    logic [3:0] block_mode;
    logic [3:0] predicted_mode;
  } out_item_t;

  // Classified item as it travels from front to back
  typedef struct packed {
    logic [3:0] pos;       // raster position inside the macroblock
    logic       is_last;   // block 15: store the macroblock afterwards
    logic       use_pred;
    logic [2:0] rem;
    logic [1:0] left_src;
    logic [3:0] left_nib;
    logic [1:0] top_src;
    logic [3:0] top_nib;
  } cls_t;

  function automatic logic [3:0] nibble(input logic [WORD_W-1:0] w, input logic [3:0] p);
    nibble = w[{p, 2'b00} +: 4];
  endfunction

endpackage

// File: src/ipmd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ipmd_ram #(
  parameter int W     = 64,
  parameter int DEPTH = 8192
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [W-1:0]                          wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                          rdata
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/ipmd_queue.sv
// Two-entry first-in first-out queue with push/full and pop/empty sides.
// No dependencies.
module ipmd_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] rdata
);

  logic [W-1:0] ent_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = ent_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold item payloads
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= wdata;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("queue count did not grow on push");

  a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop && !do_push |=> !full)
    else $error("queue still full after pop");

endmodule

// File: src/ipmd_front.sv
// Front part: holds the picture width register, reduces addresses into the store range
// and classifies each item's neighbours. Depends on ipmd_pkg.
module ipmd_front #(
  parameter int MAX_MBS = 8192
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       cfg_we,
  input  logic [ipmd_pkg::CFG_W-1:0]                 cfg_wdata,
  input  ipmd_pkg::in_item_t                         item,
  output ipmd_pkg::cls_t                             cls,
  output logic [((MAX_MBS > 1) ? $clog2(MAX_MBS) : 1)-1:0] cur_addr,
  output logic [((MAX_MBS > 1) ? $clog2(MAX_MBS) : 1)-1:0] left_addr,
  output logic [((MAX_MBS > 1) ? $clog2(MAX_MBS) : 1)-1:0] top_addr
);

  localparam int AW          = (MAX_MBS > 1) ? $clog2(MAX_MBS) : 1;
  localparam int ADDR_IN_MAX = (1 << ipmd_pkg::MB_ADDR_W) - 1;
  localparam int CFG_MAX     = (1 << ipmd_pkg::CFG_W) - 1;
  localparam logic [AW-1:0] MBS_RST = AW'(1 % MAX_MBS);

  logic [AW-1:0]                    mbs_r, mbs_nxt;
  logic [ipmd_pkg::CFG_W-1:0]       mbs_rem;
  logic [ipmd_pkg::MB_ADDR_W-1:0]   addr_rem;
  logic [1:0]                       bx, by;
  logic [3:0]                       pos;

  // Reduce the written width modulo the store depth
  always_comb begin
    mbs_rem = cfg_wdata;
    for (int k = ipmd_pkg::CFG_W - 1; k >= 0; k--) begin
      if ((MAX_MBS << k) <= CFG_MAX) begin
        if (32'(mbs_rem) >= 32'(MAX_MBS << k)) begin
          mbs_rem = mbs_rem - ipmd_pkg::CFG_W'(MAX_MBS << k);
        end
      end
    end
    mbs_nxt = cfg_we ? AW'(mbs_rem) : mbs_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbs_r <= MBS_RST;
    end else begin
      mbs_r <= mbs_nxt;
    end
  end

  // Reduce the macroblock address modulo the store depth
  always_comb begin
    addr_rem = item.mb_address;
    for (int k = ipmd_pkg::MB_ADDR_W - 1; k >= 0; k--) begin
      if ((MAX_MBS << k) <= ADDR_IN_MAX) begin
        if (32'(addr_rem) >= 32'(MAX_MBS << k)) begin
          addr_rem = addr_rem - ipmd_pkg::MB_ADDR_W'(MAX_MBS << k);
        end
      end
    end
  end

  assign cur_addr = AW'(addr_rem);

  // Neighbour addresses with wrap round the store
  always_comb begin
    if (cur_addr == '0) begin
      left_addr = AW'(MAX_MBS - 1);
    end else begin
      left_addr = cur_addr - AW'(1);
    end
    if (cur_addr >= mbs_r) begin
      top_addr = cur_addr - mbs_r;
    end else begin
      top_addr = AW'({1'b0, cur_addr} + (AW + 1)'(MAX_MBS) - {1'b0, mbs_r});
    end
  end

  // Block position from double zigzag order
  assign bx  = {item.block_index[2], item.block_index[0]};
  assign by  = {item.block_index[3], item.block_index[1]};
  assign pos = {by, bx};

  // Classify left and top neighbour sources
  always_comb begin
    cls.pos      = pos;
    cls.is_last  = (item.block_index == ipmd_pkg::LAST_BLOCK);
    cls.use_pred = item.use_predicted;
    cls.rem      = item.remaining_mode;

    if (bx != 2'd0) begin
      cls.left_src = ipmd_pkg::SRC_CUR;
      cls.left_nib = pos - 4'd1;
    end else begin
      cls.left_nib = {by, ipmd_pkg::RIGHT_COL};
      if (!item.left_available) begin
        cls.left_src = ipmd_pkg::SRC_MISS;
      end else if (item.left_is_i4) begin
        cls.left_src = ipmd_pkg::SRC_STORE;
      end else begin
        cls.left_src = ipmd_pkg::SRC_DC;
      end
    end

    if (by != 2'd0) begin
      cls.top_src = ipmd_pkg::SRC_CUR;
      cls.top_nib = pos - 4'd4;
    end else begin
      cls.top_nib = ipmd_pkg::BOTTOM_ROW + {2'b00, bx};
      if (!item.top_available) begin
        cls.top_src = ipmd_pkg::SRC_MISS;
      end else if (item.top_is_i4) begin
        cls.top_src = ipmd_pkg::SRC_STORE;
      end else begin
        cls.top_src = ipmd_pkg::SRC_DC;
      end
    end
  end

endmodule

// File: src/ipmd_back.sv
// Back part: reads neighbour macroblocks from the mode store, resolves each block's mode,
// keeps the current macroblock's modes and writes them to the store after block 15.
// Depends on ipmd_pkg and ipmd_ram.
module ipmd_back #(
  parameter int MAX_MBS = 8192
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       q_empty,
  output logic                                       q_pop,
  input  ipmd_pkg::cls_t                             q_cls,
  input  logic [((MAX_MBS > 1) ? $clog2(MAX_MBS) : 1)-1:0] q_cur_addr,
  input  logic [((MAX_MBS > 1) ? $clog2(MAX_MBS) : 1)-1:0] q_left_addr,
  input  logic [((MAX_MBS > 1) ? $clog2(MAX_MBS) : 1)-1:0] q_top_addr,
  input  logic                                       res_full,
  output logic                                       res_push,
  output ipmd_pkg::out_item_t                        res_item
);

  localparam int AW = (MAX_MBS > 1) ? $clog2(MAX_MBS) : 1;
  localparam int WW = ipmd_pkg::WORD_W;

  logic                s2_valid_r, s2_valid_nxt;
  ipmd_pkg::cls_t      s2_cls_r;
  logic [AW-1:0]       s2_addr_r;
  logic                byp_l_r, byp_t_r;
  logic [WW-1:0]       byp_data_r;
  logic [WW-1:0]       cur_r, cur_nxt;
  logic [WW-1:0]       left_rdata, top_rdata, left_word, top_word;
  logic [3:0]          mode_a, mode_b, pred, mode;
  logic                dc_only, store_we;

  // Item leaves the back stage when the result queue has room
  assign res_push     = s2_valid_r && !res_full;
  assign q_pop        = !q_empty && (!s2_valid_r || res_push);
  assign s2_valid_nxt = q_pop || (s2_valid_r && !res_push);
  assign store_we     = res_push && s2_cls_r.is_last;

  // Neighbour store, one copy per read address
  ipmd_ram #(.W(WW), .DEPTH(MAX_MBS)) u_left_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (s2_addr_r),
    .wdata (cur_nxt),
    .re    (q_pop),
    .raddr (q_left_addr),
    .rdata (left_rdata)
  );

  ipmd_ram #(.W(WW), .DEPTH(MAX_MBS)) u_top_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (s2_addr_r),
    .wdata (cur_nxt),
    .re    (q_pop),
    .raddr (q_top_addr),
    .rdata (top_rdata)
  );

  // Forward a store write that lands in the same cycle as the read
  assign left_word = byp_l_r ? byp_data_r : left_rdata;
  assign top_word  = byp_t_r ? byp_data_r : top_rdata;

  // Resolve neighbour modes
  always_comb begin
    unique case (s2_cls_r.left_src)
      ipmd_pkg::SRC_CUR:   mode_a = ipmd_pkg::nibble(cur_r, s2_cls_r.left_nib);
      ipmd_pkg::SRC_STORE: mode_a = ipmd_pkg::nibble(left_word, s2_cls_r.left_nib);
      default:             mode_a = ipmd_pkg::MODE_DC;
    endcase
    unique case (s2_cls_r.top_src)
      ipmd_pkg::SRC_CUR:   mode_b = ipmd_pkg::nibble(cur_r, s2_cls_r.top_nib);
      ipmd_pkg::SRC_STORE: mode_b = ipmd_pkg::nibble(top_word, s2_cls_r.top_nib);
      default:             mode_b = ipmd_pkg::MODE_DC;
    endcase
    dc_only = (s2_cls_r.left_src == ipmd_pkg::SRC_MISS) ||
              (s2_cls_r.top_src == ipmd_pkg::SRC_MISS);
  end

  // Predicted mode and final block mode
  always_comb begin
    if (dc_only) begin
      pred = ipmd_pkg::MODE_DC;
    end else begin
      pred = (mode_a < mode_b) ? mode_a : mode_b;
    end
    if (s2_cls_r.use_pred) begin
      mode = pred;
    end else if ({1'b0, s2_cls_r.rem} < pred) begin
      mode = {1'b0, s2_cls_r.rem};
    end else begin
      mode = {1'b0, s2_cls_r.rem} + 4'd1;
    end
    cur_nxt = cur_r;
    cur_nxt[{s2_cls_r.pos, 2'b00} +: 4] = mode;
  end

  assign res_item.block_mode     = mode;
  assign res_item.predicted_mode = pred;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      cur_r      <= '0;
      byp_l_r    <= 1'b0;
      byp_t_r    <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
      if (res_push) begin
        cur_r <= cur_nxt;
      end
      if (q_pop) begin
        byp_l_r <= store_we && (s2_addr_r == q_left_addr);
        byp_t_r <= store_we && (s2_addr_r == q_top_addr);
      end
    end
  end

  // Load the next item into the back stage
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_cls_r   <= q_cls;
      s2_addr_r  <= q_cur_addr;
      byp_data_r <= cur_nxt;
    end
  end

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (mode <= 4'd8) && (pred <= 4'd8))
    else $error("resolved mode out of range");

  a_modes_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !res_push |=> $stable(cur_r))
    else $error("current modes changed without a result");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && res_full |=> s2_valid_r && $stable(s2_cls_r))
    else $error("stalled item lost in back stage");

endmodule

// File: src/intra4x4_pred_mode_derivation.sv
// Top level of the intra 4x4 prediction mode derivation block.
// Depends on ipmd_pkg, ipmd_front, ipmd_queue and ipmd_back.
//
// One item is one 4x4 block; the block returns its resolved mode and predicted mode in
// decode order. It takes one item per cycle while results are taken: the back stage
// resolves a block combinationally, reading the current macroblock's modes from a
// register and neighbour macroblocks from a store whose read is issued as the item
// enters the back stage, with a same-cycle store write forwarded to the read. An item
// passes through the middle queue, the back stage register and the result queue before
// it shows on the result ports. The neighbour store is not cleared after reset; a
// macroblock must be stored (block 15) before a later block names it as a neighbour.
// Write the picture width only while no item is in flight.
module intra4x4_pred_mode_derivation #(
  parameter int MAX_MBS = 8192
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  ipmd_pkg::in_item_t             in_data,
  output logic                           empty,
  input  logic                           pop,
  output ipmd_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [ipmd_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int AW    = (MAX_MBS > 1) ? $clog2(MAX_MBS) : 1;
  localparam int CLS_W = $bits(ipmd_pkg::cls_t);
  localparam int MQ_W  = CLS_W + 3 * AW;
  localparam int OQ_W  = $bits(ipmd_pkg::out_item_t);

  ipmd_pkg::cls_t       f_cls, q_cls;
  logic [AW-1:0]        f_cur, f_left, f_top;
  logic [AW-1:0]        q_cur, q_left, q_top;
  logic [MQ_W-1:0]      mq_rdata;
  logic                 q_empty, q_pop;
  logic                 res_full, res_push;
  ipmd_pkg::out_item_t  res_item;
  logic [OQ_W-1:0]      oq_rdata;

  // Classify incoming items
  ipmd_front #(.MAX_MBS(MAX_MBS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (in_data),
    .cls       (f_cls),
    .cur_addr  (f_cur),
    .left_addr (f_left),
    .top_addr  (f_top)
  );

  // Decouple front and back
  ipmd_queue #(.W(MQ_W)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (full),
    .wdata ({f_cls, f_cur, f_left, f_top}),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (mq_rdata)
  );

  assign {q_cls, q_cur, q_left, q_top} = mq_rdata;

  // Resolve modes and maintain the neighbour store
  ipmd_back #(.MAX_MBS(MAX_MBS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_cls       (q_cls),
    .q_cur_addr  (q_cur),
    .q_left_addr (q_left),
    .q_top_addr  (q_top),
    .res_full    (res_full),
    .res_push    (res_push),
    .res_item    (res_item)
  );

  // Hold results until taken
  ipmd_queue #(.W(OQ_W)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .wdata (res_item),
    .pop   (pop),
    .empty (empty),
    .rdata (oq_rdata)
  );

  assign out_data = oq_rdata;

endmodule
